// ----- rtl/core/rsps_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsps_pkg: shared types and constants for the rectangle sum point store
// Widths, action and register codes, and the transaction payload structs.
// ----------------------------------------------------------------------------
package rsps_pkg;

	localparam int MAX_POINTS = 1024;
	localparam int COORD_BITS = 21;
	localparam int ADDR_W     = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CNT_W      = $clog2(MAX_POINTS + 1);
	localparam int WEIGHT_W   = 16;
	localparam int BASE_W     = 20;
	localparam int SUM_W      = 63;
	localparam int SPAN_W     = COORD_BITS + 1;
	localparam int AREA_W     = 2 * SPAN_W;
	localparam int PROD_W     = BASE_W + AREA_W;
	localparam int ACC_W      = WEIGHT_W + CNT_W;
	localparam int TOT_W      = ((PROD_W > ACC_W) ? PROD_W : ACC_W) + 1;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = (BASE_W > COORD_BITS) ? BASE_W : COORD_BITS;

	localparam logic [1:0] ACT_ADD   = 2'd0;
	localparam logic [1:0] ACT_QUERY = 2'd1;
	localparam logic [1:0] ACT_CLEAR = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_BASE_VALUE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIZE  = CFG_IDX_W'(1);

	localparam logic [COORD_BITS-1:0] GRID_RESET = {COORD_BITS{1'b1}};
	localparam logic [SUM_W-1:0]      SUM_CAP    = {SUM_W{1'b1}};

	typedef struct packed {
		logic [1:0]            action;
		logic [COORD_BITS-1:0] x_low;
		logic [COORD_BITS-1:0] y_low;
		logic [COORD_BITS-1:0] x_high;
		logic [COORD_BITS-1:0] y_high;
		logic [WEIGHT_W-1:0]   value;
	} in_t;

	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic             accepted;
		logic             is_query;
	} out_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] x_low;
		logic [COORD_BITS-1:0] y_low;
		logic [COORD_BITS-1:0] x_high;
		logic [COORD_BITS-1:0] y_high;
	} rect_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		logic [WEIGHT_W-1:0]   weight;
	} point_t;

	localparam int POINT_W = $bits(point_t);

endpackage

// ----- rtl/core/rsps_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsps_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module rsps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                          clk,
	input  logic                                          we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                              wdata,
	input  logic                                          re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                              rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/core/rsps_area.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsps_area: base value times rectangle area
// Four-stage pipeline: spans, area, split partial products, combine.
// ----------------------------------------------------------------------------
module rsps_area (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  rsps_pkg::rect_t               rect,
	input  logic [rsps_pkg::BASE_W-1:0]   base,
	output logic [rsps_pkg::PROD_W-1:0]   prod,
	output logic                          done
);
	import rsps_pkg::*;

	localparam int HALF_W = AREA_W / 2;
	localparam int PART_W = BASE_W + HALF_W;

	logic              vld_s1, vld_s2, vld_s3;
	logic [SPAN_W-1:0] dx_s1, dy_s1;
	logic [BASE_W-1:0] base_s1, base_s2;
	logic [AREA_W-1:0] area_s2;
	logic [PART_W-1:0] lo_s3, hi_s3;
	logic [PROD_W-1:0] prod_q;
	logic              done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			if (start) begin
				done_q <= 1'b0;
			end else if (vld_s3) begin
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		dx_s1   <= {1'b0, rect.x_high} - {1'b0, rect.x_low} + SPAN_W'(1);
		dy_s1   <= {1'b0, rect.y_high} - {1'b0, rect.y_low} + SPAN_W'(1);
		base_s1 <= base;
		area_s2 <= AREA_W'(dx_s1) * AREA_W'(dy_s1);
		base_s2 <= base_s1;
		lo_s3   <= PART_W'(base_s2) * PART_W'(area_s2[HALF_W-1:0]);
		hi_s3   <= PART_W'(base_s2) * PART_W'(area_s2[AREA_W-1:HALF_W]);
		if (vld_s3) begin
			prod_q <= PROD_W'(lo_s3) + (PROD_W'(hi_s3) << HALF_W);
		end
	end

	assign prod = prod_q;
	assign done = done_q;

endmodule

// ----- rtl/core/rectangle_sum_point_store_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rectangle_sum_point_store_top: weighted point store with rectangle sums
// Adds points, answers inclusive rectangle queries, clears the store.
// ----------------------------------------------------------------------------
// Usage:
//   Input transactions (in_item) move on in_valid/in_stall, results
//   (out_item) on out_valid/out_stall; a transaction completes when valid
//   is high and stall is low. Every input gives exactly one result.
//   Registers are written on cfg_valid/cfg_ready with cfg_index and
//   cfg_data; the user must write them only while the block is idle, which
//   the block itself does not enforce. cfg_ready is always high.
//   Add, clear, refused and unknown items give their result once the
//   output register is free. A query reads the stored points one per cycle
//   from the point memory; its result also waits for the area multiplier
//   pipeline. One item is in work at a time; in_stall is high while it is,
//   so the next item is taken in the cycle after a result is loaded.
//   A loaded result sits in the output register; the next item is accepted
//   meanwhile, and its result waits until the register drains.
//   Reset empties the store, sets base_value to 0 and grid_size to its
//   largest value, and drops any pending result. No clearing pass runs.
// ----------------------------------------------------------------------------
module rectangle_sum_point_store_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  rsps_pkg::in_t                    in_item,
	output logic                             out_valid,
	input  logic                             out_stall,
	output rsps_pkg::out_t                   out_item,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [rsps_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rsps_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import rsps_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_FINAL = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0]            state_q;
	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      idx_q;
	logic [BASE_W-1:0]     base_q;
	logic [COORD_BITS-1:0] grid_q;
	rect_t                 rect_q;
	logic [ACC_W-1:0]      acc_q;
	out_t                  res_q;
	out_t                  out_q;
	logic                  out_valid_q;
	logic                  rd_vld_s1;

	logic        in_acc;
	logic        add_ok;
	logic        inverted;
	logic        start_area;
	logic        ram_we;
	logic        ram_re;
	logic        out_free;
	point_t      wr_point;
	point_t      rd_point;
	rect_t       in_rect;
	logic [POINT_W-1:0]  rd_raw;
	logic [PROD_W-1:0]   prod;
	logic                prod_done;
	logic [TOT_W-1:0]    total;
	logic                hit;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || !out_stall;

	assign add_ok = (in_item.y_low != '0) && (in_item.y_low <= grid_q)
		&& (count_q < CNT_W'(MAX_POINTS));
	assign inverted = (in_item.x_low > in_item.x_high) || (in_item.y_low > in_item.y_high);

	assign in_rect.x_low  = in_item.x_low;
	assign in_rect.y_low  = in_item.y_low;
	assign in_rect.x_high = in_item.x_high;
	assign in_rect.y_high = in_item.y_high;

	assign start_area = in_acc && (in_item.action == ACT_QUERY) && !inverted;
	assign ram_we     = in_acc && (in_item.action == ACT_ADD) && add_ok;
	assign ram_re     = (state_q == ST_SCAN) && (idx_q < count_q);

	assign wr_point.x      = in_item.x_low;
	assign wr_point.y      = in_item.y_low;
	assign wr_point.weight = in_item.value;
	assign rd_point        = point_t'(rd_raw);

	assign hit = (rd_point.x >= rect_q.x_low) && (rd_point.x <= rect_q.x_high)
		&& (rd_point.y >= rect_q.y_low) && (rd_point.y <= rect_q.y_high);

	assign total = TOT_W'(prod) + TOT_W'(acc_q);

	rsps_ram #(
		.WIDTH (POINT_W),
		.DEPTH (MAX_POINTS)
	) u_points (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[ADDR_W-1:0]),
		.wdata (wr_point),
		.re    (ram_re),
		.raddr (idx_q[ADDR_W-1:0]),
		.rdata (rd_raw)
	);

	rsps_area u_area (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_area),
		.rect   (in_rect),
		.base   (base_q),
		.prod   (prod),
		.done   (prod_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			idx_q       <= '0;
			base_q      <= '0;
			grid_q      <= GRID_RESET;
			out_valid_q <= 1'b0;
			rd_vld_s1   <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_BASE_VALUE: base_q <= cfg_data[BASE_W-1:0];
					CFG_GRID_SIZE:  grid_q <= cfg_data[COORD_BITS-1:0];
					default: ;
				endcase
			end
			rd_vld_s1 <= ram_re;
			if ((state_q == ST_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					idx_q <= '0;
					if (in_acc) begin
						case (in_item.action)
							ACT_ADD: begin
								if (add_ok) begin
									count_q <= count_q + CNT_W'(1);
								end
								state_q <= ST_DONE;
							end
							ACT_QUERY: begin
								state_q <= inverted ? ST_DONE : ST_SCAN;
							end
							ACT_CLEAR: begin
								count_q <= '0;
								state_q <= ST_DONE;
							end
							default: state_q <= ST_DONE;
						endcase
					end
				end
				ST_SCAN: begin
					if (ram_re) begin
						idx_q <= idx_q + CNT_W'(1);
					end else if (!rd_vld_s1) begin
						state_q <= ST_FINAL;
					end
				end
				ST_FINAL: begin
					if (prod_done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			rect_q         <= in_rect;
			acc_q          <= '0;
			res_q.sum      <= '0;
			res_q.is_query <= (in_item.action == ACT_QUERY);
			case (in_item.action)
				ACT_ADD:   res_q.accepted <= add_ok;
				ACT_QUERY: res_q.accepted <= !inverted;
				ACT_CLEAR: res_q.accepted <= 1'b1;
				default:   res_q.accepted <= 1'b0;
			endcase
		end
		if (rd_vld_s1 && hit) begin
			acc_q <= acc_q + ACC_W'(rd_point.weight);
		end
		if ((state_q == ST_FINAL) && prod_done) begin
			res_q.sum <= (total > TOT_W'(SUM_CAP)) ? SUM_CAP : SUM_W'(total);
		end
		if ((state_q == ST_DONE) && out_free) begin
			out_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

// ----- rtl/core/rsps_chk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsps_chk: port-level checker for the rectangle sum point store
// Watches the input and output channels of the top level; attached by bind.
// ----------------------------------------------------------------------------
module rsps_chk (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_stall,
	input logic                             out_valid,
	input logic                             out_stall,
	input rsps_pkg::out_t                   out_item
);
	import rsps_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("stalled result changed or dropped");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second transaction accepted while one is in work");

	a_nonquery_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.is_query |-> out_item.sum == '0)
		else $error("non-query result carries a sum");

	a_refused_query_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.is_query && !out_item.accepted |-> out_item.sum == '0)
		else $error("refused query carries a sum");

endmodule

bind rectangle_sum_point_store_top rsps_chk u_rsps_chk (.*);
